// ===== sv/pwm_period_duty_meter_macros.svh =====
// assertion macros for the pwm period and duty meter
`ifndef PWM_PERIOD_DUTY_METER_MACROS_SVH
`define PWM_PERIOD_DUTY_METER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PDM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also checks reset itself
`define PDM_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pdm_pkg.sv =====
// shared types and constants of the pwm period and duty meter
package pdm_pkg;

  localparam int CLK_W  = 27;
  localparam int TICK_W = 16;
  localparam int DUTY_W = 7;
  localparam int STEP_W = 5;
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;

  localparam logic [CLK_W-1:0]  CLK_RESET  = 27'd16000000;
  localparam logic [DUTY_W-1:0] PCT_SCALE  = 7'd100;
  localparam logic [STEP_W-1:0] FREQ_STEPS = 5'd27;
  localparam logic [STEP_W-1:0] DUTY_STEPS = 5'd7;

  typedef enum logic [1:0] {
    PH_RISE1 = 2'd0,
    PH_FALL  = 2'd1,
    PH_RISE2 = 2'd2
  } pdm_phase_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_FREQ,
    BK_DUTY,
    BK_OUT
  } pdm_bk_state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } pdm_div_cmd_t;

endpackage

// ===== sv/pdm_if.sv =====
// edge and measurement channel interfaces
interface pdm_in_if #(parameter int CB = 16) ();
  logic          valid;
  logic          ready;
  logic          edge_rising;
  logic [CB-1:0] edge_time;

  modport source (output valid, output edge_rising, output edge_time, input ready);
  modport sink (input valid, input edge_rising, input edge_time, output ready);
endinterface

interface pdm_out_if ();
  logic                         valid;
  logic                         ready;
  logic                         in_range;
  logic [pdm_pkg::TICK_W-1:0]   high_ticks;
  logic [pdm_pkg::TICK_W-1:0]   period_ticks;
  logic [pdm_pkg::CLK_W-1:0]    frequency_hz;
  logic [pdm_pkg::DUTY_W-1:0]   duty_percent;

  modport source (output valid, output in_range, output high_ticks, output period_ticks,
                  output frequency_hz, output duty_percent, input ready);
  modport sink (input valid, input in_range, input high_ticks, input period_ticks,
                input frequency_hz, input duty_percent, output ready);
endinterface

// ===== sv/pwm_period_duty_meter.sv =====
// top level of the pwm period and duty meter
// edges that do not finish a measurement are taken one per cycle while the queue has room
// a result goes from its closing edge through the queue and the idle, load and output states, an in-range one also
// through the frequency and duty divides; the back end takes a new queue entry only after the last one is output,
// and one shared divider does both the 27-step frequency divide and the 7-step duty divide
// reset clears the edge phase, queue, divider and output valid and loads 16000000 as clock rate
module pwm_period_duty_meter #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  pdm_in_if.sink                    in_chan,
  pdm_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic [pdm_pkg::CLK_W-1:0] cfg_wdata
);

  localparam int W = 2*COUNTER_BITS + 1;

  logic         q_push;
  logic         q_pop;
  logic         q_full;
  logic         q_empty;
  logic [W-1:0] q_wdata;
  logic [W-1:0] q_rdata;

  pdm_front #(.CB(COUNTER_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  pdm_queue #(.W(W)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  pdm_back #(.CB(COUNTER_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_chan  (out_chan)
  );

endmodule

// ===== sv/pdm_queue.sv =====
// two-entry measurement queue between front and back
module pdm_queue #(
  parameter int W = 33
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  localparam int AW = pdm_pkg::QAW;
  localparam int D  = pdm_pkg::QDEPTH;

  logic [W-1:0]  mem_r [D];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;

  assign full  = (count_r == (AW+1)'(D));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/pdm_front.sv =====
// edge sequencing and interval classification
module pdm_front #(
  parameter int CB = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  pdm_in_if.sink        in_chan,
  input  logic          q_full,
  output logic          q_push,
  output logic [2*CB:0] q_data
);

  pdm_pkg::pdm_phase_t phase_r, phase_nxt;
  logic [CB-1:0] rise1_r;
  logic [CB-1:0] fall_r;
  logic          acc;
  logic          rising;
  logic [CB-1:0] t;
  logic          in_range;
  logic [CB-1:0] high;
  logic [CB-1:0] period;

  assign in_chan.ready = !q_full;
  assign acc    = in_chan.valid && !q_full;
  assign rising = in_chan.edge_rising;
  assign t      = in_chan.edge_time;

  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      unique case (phase_r)
        pdm_pkg::PH_FALL: begin
          if (!rising) phase_nxt = pdm_pkg::PH_RISE2;
        end
        pdm_pkg::PH_RISE2: begin
          if (rising) phase_nxt = pdm_pkg::PH_RISE1;
        end
        default: begin
          if (rising) phase_nxt = pdm_pkg::PH_FALL;
        end
      endcase
    end
  end

  always_comb begin
    in_range = (fall_r > rise1_r) && (fall_r < t);
    high     = fall_r - rise1_r;
    period   = t - rise1_r;
    q_push   = acc && rising && (phase_r == pdm_pkg::PH_RISE2);
    q_data   = {in_range, in_range ? high : '0, in_range ? period : '0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pdm_pkg::PH_RISE1;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && rising && phase_r != pdm_pkg::PH_FALL && phase_r != pdm_pkg::PH_RISE2) begin
      rise1_r <= t;
    end
    if (acc && !rising && phase_r == pdm_pkg::PH_FALL) begin
      fall_r <= t;
    end
  end

endmodule

// ===== sv/pdm_div.sv =====
// shared restoring divider, one quotient bit per cycle
module pdm_div #(
  parameter int CB = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pdm_pkg::pdm_div_cmd_t      cmd,
  input  logic [CB-1:0]              rem_init,
  input  logic [pdm_pkg::CLK_W-1:0]  dvd_init,
  input  logic [CB-1:0]              divisor,
  output logic [pdm_pkg::CLK_W-1:0]  quot,
  output logic                       done
);

  localparam int DW = pdm_pkg::CLK_W;

  logic [CB-1:0]              rem_r;
  logic [DW-1:0]              dvd_r;
  logic [DW-1:0]              q_r;
  logic [pdm_pkg::STEP_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [CB:0]                sh;
  logic [CB:0]                diff;
  logic                       ge;
  logic [CB-1:0]              rem_step;

  always_comb begin
    sh       = {rem_r, dvd_r[DW-1]};
    diff     = sh - {1'b0, divisor};
    ge       = (sh >= {1'b0, divisor});
    rem_step = ge ? diff[CB-1:0] : sh[CB-1:0];
  end

  assign quot = q_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= cmd.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - pdm_pkg::STEP_W'(1);
        if (cnt_r == pdm_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r <= rem_init;
      dvd_r <= dvd_init;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_step;
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      q_r   <= {q_r[DW-2:0], ge};
    end
  end

endmodule

// ===== sv/pdm_back.sv =====
// measurement arithmetic sequencer and output register
module pdm_back #(
  parameter int CB = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  logic [2*CB:0]             q_data,
  output logic                      q_pop,
  input  logic                      cfg_we,
  input  logic [pdm_pkg::CLK_W-1:0] cfg_wdata,
  pdm_out_if.source                 out_chan
);

  localparam int DW = pdm_pkg::CLK_W;
  localparam int TW = pdm_pkg::TICK_W;
  localparam int PW = pdm_pkg::DUTY_W;

  pdm_pkg::pdm_bk_state_t state_r, state_nxt;
  pdm_pkg::pdm_div_cmd_t  cmd;

  logic [DW-1:0]   clk_hz_r;
  logic            ent_in_range_r;
  logic [CB-1:0]   ent_high_r;
  logic [CB-1:0]   ent_period_r;
  logic [CB+PW-1:0] prod_r;
  logic [DW-1:0]   freq_r;
  logic [PW-1:0]   duty_r;
  logic            out_valid_r, out_valid_nxt;
  logic            out_in_range_r;
  logic [TW-1:0]   out_high_r;
  logic [TW-1:0]   out_period_r;
  logic [DW-1:0]   out_freq_r;
  logic [PW-1:0]   out_duty_r;
  logic            out_load;
  logic [CB-1:0]   rem_init;
  logic [DW-1:0]   dvd_init;
  logic [DW-1:0]   quot;
  logic            div_done;

  pdm_div #(.CB(CB)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .rem_init (rem_init),
    .dvd_init (dvd_init),
    .divisor  (ent_period_r),
    .quot     (quot),
    .done     (div_done)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pdm_pkg::BK_IDLE: begin
        if (!q_empty) state_nxt = pdm_pkg::BK_LOAD;
      end
      pdm_pkg::BK_LOAD: begin
        state_nxt = ent_in_range_r ? pdm_pkg::BK_FREQ : pdm_pkg::BK_OUT;
      end
      pdm_pkg::BK_FREQ: begin
        if (div_done) state_nxt = pdm_pkg::BK_DUTY;
      end
      pdm_pkg::BK_DUTY: begin
        if (div_done) state_nxt = pdm_pkg::BK_OUT;
      end
      pdm_pkg::BK_OUT: begin
        if (out_load) state_nxt = pdm_pkg::BK_IDLE;
      end
      default: state_nxt = pdm_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state_r == pdm_pkg::BK_IDLE) && !q_empty;
    out_load  = (state_r == pdm_pkg::BK_OUT) && (!out_valid_r || out_chan.ready);
    cmd.start = 1'b0;
    cmd.steps = pdm_pkg::FREQ_STEPS;
    rem_init  = prod_r[CB+PW-1:PW];
    dvd_init  = {prod_r[PW-1:0], (DW-PW)'(0)};
    unique case (state_r)
      pdm_pkg::BK_LOAD: begin
        cmd.start = ent_in_range_r;
        rem_init  = '0;
        dvd_init  = clk_hz_r;
      end
      pdm_pkg::BK_FREQ: begin
        cmd.start = div_done;
        cmd.steps = pdm_pkg::DUTY_STEPS;
      end
      default: begin
      end
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pdm_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      clk_hz_r    <= pdm_pkg::CLK_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) clk_hz_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      {ent_in_range_r, ent_high_r, ent_period_r} <= q_data;
    end
    if (state_r == pdm_pkg::BK_LOAD) begin
      prod_r <= (CB+PW)'(ent_high_r) * (CB+PW)'(pdm_pkg::PCT_SCALE);
    end
    if (state_r == pdm_pkg::BK_FREQ && div_done) begin
      freq_r <= quot;
    end
    if (state_r == pdm_pkg::BK_DUTY && div_done) begin
      duty_r <= quot[PW-1:0];
    end
    if (out_load) begin
      out_in_range_r <= ent_in_range_r;
      out_high_r     <= ent_in_range_r ? TW'(ent_high_r) : '0;
      out_period_r   <= ent_in_range_r ? TW'(ent_period_r) : '0;
      out_freq_r     <= ent_in_range_r ? freq_r : '0;
      out_duty_r     <= ent_in_range_r ? duty_r : '0;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.in_range     = out_in_range_r;
  assign out_chan.high_ticks   = out_high_r;
  assign out_chan.period_ticks = out_period_r;
  assign out_chan.frequency_hz = out_freq_r;
  assign out_chan.duty_percent = out_duty_r;

endmodule

// ===== sv/pdm_checker.sv =====
// port-level checks of the pwm period and duty meter and their binding
`include "pwm_period_duty_meter_macros.svh"

module pdm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       in_range,
  input logic [pdm_pkg::TICK_W-1:0] high_ticks,
  input logic [pdm_pkg::TICK_W-1:0] period_ticks,
  input logic [pdm_pkg::CLK_W-1:0]  frequency_hz,
  input logic [pdm_pkg::DUTY_W-1:0] duty_percent
);

  `PDM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(in_range) && $stable(high_ticks) && $stable(period_ticks) && $stable(frequency_hz) && $stable(duty_percent), "stalled item changed")
  `PDM_ASSERT_NOW(a_out_zero, out_valid && !in_range, high_ticks == '0 && period_ticks == '0 && frequency_hz == '0 && duty_percent == '0, "out-of-range item not zero")
  `PDM_ASSERT_NOW(a_duty_bound, out_valid && in_range, duty_percent < pdm_pkg::PCT_SCALE, "duty above range")
  `PDM_ASSERT_RST(a_rst_clear, !rst_n, !out_valid, "output valid after reset")

endmodule

bind pwm_period_duty_meter pdm_checker u_pdm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .in_range     (out_chan.in_range),
  .high_ticks   (out_chan.high_ticks),
  .period_ticks (out_chan.period_ticks),
  .frequency_hz (out_chan.frequency_hz),
  .duty_percent (out_chan.duty_percent)
);
